>>> sv/nfhe_pkg.sv
`default_nettype none
package nfhe_pkg;

  localparam int DIGEST_BYTES = 16;
  localparam int OUT_CHARS    = 22;
  localparam int QUEUE_DEPTH  = 2;

  localparam logic [3:0] LAST_SLOT = 4'(DIGEST_BYTES - 1);
  localparam logic [2:0] TAIL_GRP  = 3'd5;

  localparam logic [0:63][7:0] ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz-1234567890_";

  typedef logic [DIGEST_BYTES-1:0][7:0] digest_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [6:0] sym_to_char(input logic [5:0] sym);
    logic [7:0] c;
    c = ALPHABET[sym];
    return c[6:0];
  endfunction

endpackage
`default_nettype wire

>>> sv/nfhe_front.sv
`default_nettype none
module nfhe_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [7:0]        name_byte,
  input  wire logic              last_byte,
  input  wire nfhe_pkg::q_stat_t q_stat,
  output logic                   push,
  output nfhe_pkg::digest_t      push_data
);

  nfhe_pkg::digest_t digest;
  logic [3:0]        pos;
  logic              past;
  logic [7:0]        count;

  logic              acc;
  logic [7:0]        new_val;
  logic [7:0]        count_next;

  assign in_stall   = q_stat.full;
  assign acc        = in_valid && !in_stall;
  assign count_next = count + 8'd1;
  assign new_val    = past ? (digest[pos] ^ ~{name_byte[6:0], name_byte[7]}) : name_byte;
  assign push       = acc && last_byte;

  always_comb begin
    push_data      = digest;
    push_data[pos] = new_val;
    push_data[0]   = push_data[0] ^ count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      digest <= '0;
      pos    <= '0;
      past   <= 1'b0;
      count  <= '0;
    end else if (acc) begin
      if (last_byte) begin
        digest <= '0;
        pos    <= '0;
        past   <= 1'b0;
        count  <= '0;
      end else begin
        digest[pos] <= new_val;
        pos         <= pos + 4'd1;
        past        <= past || (pos == nfhe_pkg::LAST_SLOT);
        count       <= count_next;
      end
    end
  end

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    push |=> (pos == 4'd0 && count == 8'd0 && !past))
    else $error("front state not cleared after final word");

  a_past_after_slot15: assert property (@(posedge clk) disable iff (rst)
    (acc && !last_byte && pos == nfhe_pkg::LAST_SLOT) |=> past)
    else $error("fold mode not entered after first block");

endmodule
`default_nettype wire

>>> sv/nfhe_queue.sv
`default_nettype none
module nfhe_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire nfhe_pkg::digest_t push_data,
  input  wire logic              pop,
  output nfhe_pkg::digest_t      pop_data,
  output nfhe_pkg::q_stat_t      q_stat
);

  nfhe_pkg::digest_t mem [nfhe_pkg::QUEUE_DEPTH];
  logic              wr_ptr;
  logic              rd_ptr;
  logic [1:0]        fill;

  assign q_stat.full  = (fill == 2'(nfhe_pkg::QUEUE_DEPTH));
  assign q_stat.empty = (fill == 2'd0);
  assign pop_data     = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      fill <= fill + 2'(push) - 2'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_stat.full)
    else $error("queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_stat.empty)
    else $error("queue underflow");

endmodule
`default_nettype wire

>>> sv/nfhe_back.sv
`default_nettype none
module nfhe_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire nfhe_pkg::q_stat_t q_stat,
  input  wire nfhe_pkg::digest_t pop_data,
  output logic                   pop,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [6:0]             hash_char,
  output logic                   last_char
);

  nfhe_pkg::digest_t dig;
  logic              busy;
  logic [2:0]        grp;
  logic [1:0]        sub;

  logic              can_load;
  logic              is_tail;
  logic              is_end;
  logic [5:0]        sym;

  assign can_load = !out_valid || !out_stall;
  assign pop      = !busy && !q_stat.empty;
  assign is_tail  = (grp == nfhe_pkg::TAIL_GRP);
  assign is_end   = is_tail && (sub == 2'd1);

  always_comb begin
    if (is_tail) begin
      sym = (sub == 2'd0) ? dig[0][7:2] : {4'b0000, dig[0][1:0]};
    end else begin
      case (sub)
        2'd0:    sym = dig[0][7:2];
        2'd1:    sym = dig[1][7:2];
        2'd2:    sym = dig[2][7:2];
        default: sym = {dig[2][1:0], dig[1][1:0], dig[0][1:0]};
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      grp       <= '0;
      sub       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (busy && can_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (busy) begin
        if (can_load) begin
          hash_char <= nfhe_pkg::sym_to_char(sym);
          last_char <= is_end;
          if (is_end) begin
            busy <= 1'b0;
          end else if (sub == 2'd3) begin
            sub <= '0;
            grp <= grp + 3'd1;
            dig <= {24'd0, dig[15:3]};
          end else begin
            sub <= sub + 2'd1;
          end
        end
      end else if (pop) begin
        dig  <= pop_data;
        busy <= 1'b1;
        grp  <= '0;
        sub  <= '0;
      end
    end
  end

  a_tail_two_chars: assert property (@(posedge clk) disable iff (rst)
    (busy && is_tail) |-> (sub == 2'd0 || sub == 2'd1))
    else $error("tail group runs past two characters");

  a_idle_after_end: assert property (@(posedge clk) disable iff (rst)
    (busy && can_load && is_end) |=> (!busy && out_valid && last_char))
    else $error("run did not close on final character");

endmodule
`default_nettype wire

>>> sv/name_fold_hash_encoder.sv
`default_nettype none
// Name fold hash encoder. Name bytes enter one per cycle on the input channel
// while in_stall is low; the first 16 fill a 16-byte digest, later ones are
// rotated, inverted and folded in, and the word flagged last_byte closes the
// name. Each closed digest goes through a two-entry queue to the encoder,
// which sends 22 characters, one per cycle while out_stall allows, with
// last_char on the final one. The input stalls only while the queue holds
// two digests not yet taken by the encoder. Characters leave from the output
// register, and between digests the encoder loads the next one from the queue.
module name_fold_hash_encoder (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] name_byte,
  input  wire logic       last_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [6:0]      hash_char,
  output logic            last_char
);

  nfhe_pkg::q_stat_t q_stat;
  nfhe_pkg::digest_t push_data;
  nfhe_pkg::digest_t pop_data;
  logic              push;
  logic              pop;

  nfhe_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .name_byte (name_byte),
    .last_byte (last_byte),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data)
  );

  nfhe_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .q_stat    (q_stat)
  );

  nfhe_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_stat    (q_stat),
    .pop_data  (pop_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .hash_char (hash_char),
    .last_char (last_char)
  );

endmodule
`default_nettype wire
